// File: hw/rtl/lsd_pkg.sv
`timescale 1ns / 1ps

package lsd_pkg;

  localparam int STACK_DEPTH = 16;

  localparam int DATA_W  = 32;
  localparam int CMD_W   = 2;
  localparam int DEPTH_W = 4;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_DEPTH     = 2'd3
  } status_e;

endpackage

// File: hw/rtl/lsd_ifs.sv
`timescale 1ns / 1ps

interface lsd_cmd_if;
  import lsd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [DATA_W-1:0]  push_value;
  logic [DEPTH_W-1:0]        depth_from_top;

  modport source (output valid, command, push_value, depth_from_top, input ready);
  modport sink   (input valid, command, push_value, depth_from_top, output ready);
endinterface

interface lsd_rsp_if;
  import lsd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  read_value;
  logic [STAT_W-1:0]         status;
  logic [COUNT_W-1:0]        entry_count;
  logic                      is_empty;

  modport source (output valid, read_value, status, entry_count, is_empty, input ready);
  modport sink   (input valid, read_value, status, entry_count, is_empty, output ready);
endinterface

// File: hw/rtl/lsd_ram.sv
`timescale 1ns / 1ps

module lsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lifo_stack_delete_at_depth.sv
`timescale 1ns / 1ps
// Push, failed pop/delete, delete of the top: result registered as the request is taken.
// Pop: one RAM read first. Delete at depth d > 0: d entries moved one slot lower, one entry
// per cycle, through the single read port and single write port of the entry RAM.
// Throughput: one request at a time; next request is taken once the result is registered.
// Reset: asynchronous, active low; count and control cleared, RAM contents left as is.
module lifo_stack_delete_at_depth (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsd_cmd_if.sink    cmd_i,
  lsd_rsp_if.source  rsp_o
);
  import lsd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DEL,
    S_HOLD
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   rp_q;
  logic [PTR_W-1:0]   wa_q;
  logic               wv_q;

  logic [DATA_W-1:0]  res_val_q;
  logic [STAT_W-1:0]  res_st_q;
  logic [CNT_W-1:0]   res_cnt_q;

  logic               out_valid_q;
  logic [DATA_W-1:0]  out_val_q;
  logic [STAT_W-1:0]  out_st_q;
  logic [CNT_W-1:0]   out_cnt_q;

  logic               accept;
  logic               out_free;
  logic               full;
  logic               empty;
  logic               del_ok;
  logic [CMP_W-1:0]   depth_ext;
  logic [CMP_W-1:0]   cnt_ext;
  logic [CMP_W-1:0]   pos_ext;
  logic [CNT_W-1:0]   pos_w;
  logic [CNT_W-1:0]   pos_p1;
  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   cnt_p1;
  logic [CNT_W-1:0]   rp_m1;

  logic               ram_we;
  logic [PTR_W-1:0]   ram_waddr;
  logic [DATA_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [PTR_W-1:0]   ram_raddr;
  logic [DATA_W-1:0]  ram_rdata;

  logic               fin;
  logic [DATA_W-1:0]  fin_val;
  logic [STAT_W-1:0]  fin_st;
  logic [CNT_W-1:0]   fin_cnt;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign full      = (count_q == CNT_W'(STACK_DEPTH));
  assign empty     = (count_q == '0);
  assign depth_ext = CMP_W'(cmd_i.depth_from_top);
  assign cnt_ext   = CMP_W'(count_q);
  assign del_ok    = (depth_ext < cnt_ext);
  assign pos_ext   = cnt_ext - depth_ext - CMP_W'(1);
  assign pos_w     = pos_ext[CNT_W-1:0];
  assign pos_p1    = pos_w + CNT_W'(1);
  assign cnt_m1    = count_q - CNT_W'(1);
  assign cnt_p1    = count_q + CNT_W'(1);
  assign rp_m1     = rp_q - CNT_W'(1);

  lsd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wa_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = '0;
    fin       = 1'b0;
    fin_val   = '0;
    fin_st    = ST_OK;
    fin_cnt   = count_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i.command)
            CMD_PUSH: begin
              fin = 1'b1;
              if (full) begin
                fin_st = ST_OVERFLOW;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[PTR_W-1:0];
                ram_wdata = cmd_i.push_value;
                fin_cnt   = cnt_p1;
              end
            end
            CMD_POP: begin
              if (empty) begin
                fin     = 1'b1;
                fin_val = '1;
                fin_st  = ST_UNDERFLOW;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = cnt_m1[PTR_W-1:0];
              end
            end
            CMD_DELETE: begin
              if (!del_ok) begin
                fin    = 1'b1;
                fin_st = ST_DEPTH;
              end else if (cmd_i.depth_from_top == '0) begin
                fin     = 1'b1;
                fin_cnt = cnt_m1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = pos_p1[PTR_W-1:0];
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        fin     = 1'b1;
        fin_val = ram_rdata;
        fin_cnt = cnt_m1;
      end
      S_DEL: begin
        // write back the entry read last cycle one slot lower
        ram_we = wv_q;
        if (rp_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = rp_q[PTR_W-1:0];
        end else begin
          fin     = 1'b1;
          fin_cnt = cnt_m1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rp_q        <= '0;
      wa_q        <= '0;
      wv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (cmd_i.command == CMD_POP && !empty) begin
              state_q <= S_POP;
            end
            if (cmd_i.command == CMD_DELETE && del_ok && cmd_i.depth_from_top != '0) begin
              state_q <= S_DEL;
              rp_q    <= pos_w + CNT_W'(2);
              wa_q    <= pos_w[PTR_W-1:0];
              wv_q    <= 1'b1;
            end
          end
        end
        S_DEL: begin
          if (rp_q < count_q) begin
            wv_q <= 1'b1;
            wa_q <= rp_m1[PTR_W-1:0];
            rp_q <= rp_q + CNT_W'(1);
          end else begin
            wv_q <= 1'b0;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_val_q   <= res_val_q;
            out_st_q    <= res_st_q;
            out_cnt_q   <= res_cnt_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
        end
      endcase
      if (fin) begin
        count_q <= fin_cnt;
        if (out_free) begin
          out_valid_q <= 1'b1;
          out_val_q   <= fin_val;
          out_st_q    <= fin_st;
          out_cnt_q   <= fin_cnt;
          state_q     <= S_IDLE;
        end else begin
          res_val_q <= fin_val;
          res_st_q  <= fin_st;
          res_cnt_q <= fin_cnt;
          state_q   <= S_HOLD;
        end
      end
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_value  = out_val_q;
  assign rsp_o.status      = out_st_q;
  assign rsp_o.entry_count = COUNT_W'(out_cnt_q);
  assign rsp_o.is_empty    = (out_cnt_q == '0);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("entry count above stack depth");

  a_rp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEL) |-> (rp_q <= count_q && wv_q))
    else $error("delete shift pointer out of range");

  a_hold_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HOLD) |-> out_valid_q)
    else $error("result held while output register free");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("pop did not decrement count");

endmodule
